// ===== sv/idiff_pkg.sv =====
package idiff_pkg;

	// Largest frame side and the widths that follow from it
	localparam int MAX_SIDE = 8192;
	localparam int COORD_W  = $clog2(MAX_SIDE);
	localparam int SIZE_W   = COORD_W + 1;
	localparam int CNT_W    = 2 * COORD_W + 1;
	localparam int SUM_W    = 36;
	localparam int CHAN_W   = 8;
	localparam int DSUM_W   = CHAN_W + 2;

	// Stream widths
	localparam int IN_W  = 6 * CHAN_W;
	localparam int OUT_W = 144;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd4;

	// Result kinds carried on tuser
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Highlight offset and channel saturation
	localparam logic [CHAN_W:0]   HILITE_OFS = 9'd80;
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

	typedef struct packed {
		logic [SIZE_W-1:0] overlap_width;
		logic [SIZE_W-1:0] overlap_height;
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
	} geom_t;

	typedef struct packed {
		logic              mismatch;
		logic [DSUM_W-1:0] diff_sum;
	} upd_t;

	typedef struct packed {
		logic in_overlap;
		logic frame_end;
	} pos_t;

	typedef struct packed {
		logic               box_valid;
		logic [COORD_W-1:0] box_bottom;
		logic [COORD_W-1:0] box_right;
		logic [COORD_W-1:0] box_top;
		logic [COORD_W-1:0] box_left;
		logic [SUM_W-1:0]   abs_diff_sum;
		logic [CNT_W-1:0]   mismatch_count;
	} sum_t;

	// Divide an 8-bit channel by three: multiply by 171/512, exact over 0..255
	function automatic logic [CHAN_W-1:0] div3(input logic [CHAN_W-1:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd171;
		return {1'b0, p[15:9]};
	endfunction

	// Absolute difference of two channels
	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Highlight channel: 80 plus the difference, saturated
	function automatic logic [CHAN_W-1:0] plus80(input logic [CHAN_W-1:0] d);
		logic [CHAN_W:0] s;
		s = HILITE_OFS + {1'b0, d};
		return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
	endfunction

endpackage

// ===== sv/idiff_stats.sv =====
// Raster position and frame statistics
module idiff_stats (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  idiff_pkg::geom_t                     geom,
	input  logic                                 step,
	input  idiff_pkg::upd_t                      upd,
	output idiff_pkg::pos_t                      pos,
	output idiff_pkg::sum_t                      summary
);

	logic [idiff_pkg::COORD_W-1:0] column_q, row_q;
	logic [idiff_pkg::CNT_W-1:0]   mism_q, mism_n;
	logic [idiff_pkg::SUM_W-1:0]   total_q, total_n;
	logic [idiff_pkg::COORD_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [idiff_pkg::COORD_W-1:0] left_n, top_n, right_n, bottom_n;
	logic [idiff_pkg::COORD_W-1:0] col_last, row_last;
	logic                          in_ov, hit, last_col, last_row, box_v;

	// Last index of a frame side, with the side clamped to 1..MAX_SIDE
	function automatic logic [idiff_pkg::COORD_W-1:0] side_last(
			input logic [idiff_pkg::SIZE_W-1:0] v);
		logic [idiff_pkg::SIZE_W-1:0] m;
		m = v - idiff_pkg::SIZE_W'(1);
		if (v == '0)
			return '0;
		else if (v > idiff_pkg::SIZE_W'(idiff_pkg::MAX_SIDE))
			return idiff_pkg::COORD_W'(idiff_pkg::MAX_SIDE - 1);
		else
			return m[idiff_pkg::COORD_W-1:0];
	endfunction

	// Locate the current pixel
	always_comb begin
		col_last = side_last(geom.frame_width);
		row_last = side_last(geom.frame_height);
		last_col = column_q >= col_last;
		last_row = row_q >= row_last;
		in_ov    = ({1'b0, column_q} < geom.overlap_width) &&
			({1'b0, row_q} < geom.overlap_height);
		hit      = in_ov && upd.mismatch;
	end

	assign pos.in_overlap = in_ov;
	assign pos.frame_end  = last_col && last_row;

	// Fold this pixel into the statistics
	always_comb begin
		mism_n   = mism_q + idiff_pkg::CNT_W'(hit);
		total_n  = total_q + (in_ov ? idiff_pkg::SUM_W'(upd.diff_sum) : '0);
		left_n   = (hit && column_q < left_q)   ? column_q : left_q;
		top_n    = (hit && row_q < top_q)       ? row_q    : top_q;
		right_n  = (hit && column_q > right_q)  ? column_q : right_q;
		bottom_n = (hit && row_q > bottom_q)    ? row_q    : bottom_q;
		box_v    = mism_n != '0;
	end

	// Summary as it stands after this pixel
	always_comb begin
		summary.mismatch_count = mism_n;
		summary.abs_diff_sum   = total_n;
		summary.box_valid      = box_v;
		summary.box_left       = box_v ? left_n   : '0;
		summary.box_top        = box_v ? top_n    : '0;
		summary.box_right      = box_v ? right_n  : '0;
		summary.box_bottom     = box_v ? bottom_n : '0;
	end

	// Advance position; restart statistics after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			mism_q   <= '0;
			total_q  <= '0;
			left_q   <= '1;
			top_q    <= '1;
			right_q  <= '0;
			bottom_q <= '0;
		end else if (step) begin
			if (last_col && last_row) begin
				column_q <= '0;
				row_q    <= '0;
				mism_q   <= '0;
				total_q  <= '0;
				left_q   <= '1;
				top_q    <= '1;
				right_q  <= '0;
				bottom_q <= '0;
			end else begin
				if (last_col) begin
					column_q <= '0;
					row_q    <= row_q + idiff_pkg::COORD_W'(1);
				end else begin
					column_q <= column_q + idiff_pkg::COORD_W'(1);
				end
				mism_q   <= mism_n;
				total_q  <= total_n;
				left_q   <= left_n;
				top_q    <= top_n;
				right_q  <= right_n;
				bottom_q <= bottom_n;
			end
		end
	end

	// A step from the last column restarts the column
	a_col_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_col) |=> (column_q == '0))
		else $error("column did not wrap");

	// Outside a frame end, box edges only move with a counted mismatch
	a_box_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !hit && !pos.frame_end) |=> $stable(left_q) && $stable(right_q))
		else $error("box moved without mismatch");

	// A counted mismatch leaves a nonzero count in the summary
	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> summary.box_valid)
		else $error("mismatch not counted");

endmodule

// ===== sv/image_diff_engine.sv =====
// Streaming RGB image comparator. Reference/rendered pixel pairs enter in raster
// order over frame_width x frame_height (each side clamped to 1..8192); the block
// tracks column and row itself. Each pixel yields one diff pixel result (tuser 0):
// magenta outside the overlap, a red highlight with green and blue at 80 plus the
// red and blue differences when any channel differs by more than tolerance, else
// the reference divided by three. The last pixel of a frame is followed by a
// summary result (tuser 1, tlast 1) with mismatch count, sum of absolute
// differences and bounding box. Rate: one pixel per clock unless the output
// stalls, set by the single registered compare/accumulate pass; the last pixel
// of a frame holds the input while the output register emits pixel and summary
// back to back. No clearing pass after reset. Write configuration only while idle.
module image_diff_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [idiff_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [idiff_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input pixel pairs
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// ref_red, ref_green, ref_blue, new_red, new_green, new_blue
	input  logic [idiff_pkg::IN_W-1:0]          s_axis_tdata,
	// results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pix_red, pix_green, pix_blue, mismatch_count, abs_diff_sum, box_left,
	// box_top, box_right, box_bottom, box_valid, zero pad
	output logic [idiff_pkg::OUT_W-1:0]         m_axis_tdata,
	// kind
	output logic                                m_axis_tuser,
	// final_res
	output logic                                m_axis_tlast
);

	localparam int CW = idiff_pkg::CHAN_W;

	logic [CW-1:0]                 tol_q;
	idiff_pkg::geom_t              geom_q;
	logic                          s1_v_q;
	logic [idiff_pkg::IN_W-1:0]    data_s1;
	logic                          pix_v_q, sum_v_q;
	logic [3*CW-1:0]               pix_q;
	idiff_pkg::sum_t               sum_q;
	logic                          pop, load_ok, s1_adv;
	logic [CW-1:0]                 dr, dg, db, out_r, out_g, out_b;
	logic                          mism;
	idiff_pkg::upd_t               upd;
	idiff_pkg::pos_t               pos;
	idiff_pkg::sum_t               summary;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q                 <= '0;
			geom_q.overlap_width  <= idiff_pkg::SIZE_W'(1);
			geom_q.overlap_height <= idiff_pkg::SIZE_W'(1);
			geom_q.frame_width    <= idiff_pkg::SIZE_W'(1);
			geom_q.frame_height   <= idiff_pkg::SIZE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				idiff_pkg::REG_TOLERANCE:      tol_q <= cfg_data[CW-1:0];
				idiff_pkg::REG_OVERLAP_WIDTH:  geom_q.overlap_width  <= cfg_data;
				idiff_pkg::REG_OVERLAP_HEIGHT: geom_q.overlap_height <= cfg_data;
				idiff_pkg::REG_FRAME_WIDTH:    geom_q.frame_width    <= cfg_data;
				idiff_pkg::REG_FRAME_HEIGHT:   geom_q.frame_height   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: the output stage takes an item once it will be empty
	always_comb begin
		pop           = m_axis_tvalid && m_axis_tready;
		load_ok       = (!pix_v_q && !sum_v_q) || (pop && !(pix_v_q && sum_v_q));
		s1_adv        = s1_v_q && load_ok;
		s_axis_tready = !s1_v_q || load_ok;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	// Channel differences and diff pixel
	always_comb begin
		dr   = idiff_pkg::absdiff(data_s1[0*CW +: CW], data_s1[3*CW +: CW]);
		dg   = idiff_pkg::absdiff(data_s1[1*CW +: CW], data_s1[4*CW +: CW]);
		db   = idiff_pkg::absdiff(data_s1[2*CW +: CW], data_s1[5*CW +: CW]);
		mism = (dr > tol_q) || (dg > tol_q) || (db > tol_q);
		upd.mismatch = mism;
		upd.diff_sum = idiff_pkg::DSUM_W'(dr) + idiff_pkg::DSUM_W'(dg) +
			idiff_pkg::DSUM_W'(db);
		if (!pos.in_overlap) begin
			out_r = idiff_pkg::CHAN_MAX;
			out_g = '0;
			out_b = idiff_pkg::CHAN_MAX;
		end else if (mism) begin
			out_r = idiff_pkg::CHAN_MAX;
			out_g = idiff_pkg::plus80(dr);
			out_b = idiff_pkg::plus80(db);
		end else begin
			out_r = idiff_pkg::div3(data_s1[0*CW +: CW]);
			out_g = idiff_pkg::div3(data_s1[1*CW +: CW]);
			out_b = idiff_pkg::div3(data_s1[2*CW +: CW]);
		end
	end

	idiff_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom_q),
		.step    (s1_adv),
		.upd     (upd),
		.pos     (pos),
		.summary (summary)
	);

	// Output stage: pixel result, then the summary when the frame ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_q <= 1'b0;
			sum_v_q <= 1'b0;
		end else if (s1_adv) begin
			pix_v_q <= 1'b1;
			sum_v_q <= pos.frame_end;
		end else if (pop) begin
			if (pix_v_q) begin
				pix_v_q <= 1'b0;
			end else begin
				sum_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pix_q <= {out_b, out_g, out_r};
			sum_q <= summary;
		end
	end

	// Present the pending result
	always_comb begin
		m_axis_tvalid = pix_v_q || sum_v_q;
		if (pix_v_q) begin
			m_axis_tdata = {{(idiff_pkg::OUT_W - 3*CW){1'b0}}, pix_q};
			m_axis_tuser = idiff_pkg::KIND_PIXEL;
			m_axis_tlast = 1'b0;
		end else begin
			m_axis_tdata = {{(idiff_pkg::OUT_W - 3*CW - $bits(sum_q)){1'b0}},
				sum_q, {(3*CW){1'b0}}};
			m_axis_tuser = idiff_pkg::KIND_SUMMARY;
			m_axis_tlast = 1'b1;
		end
	end

	// A frame end loads both results at once
	a_frame_end_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && pos.frame_end) |=> pix_v_q && sum_v_q)
		else $error("summary not queued at frame end");

	// No new item while a summary still waits behind a pixel
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_v_q && sum_v_q) |-> !s1_adv)
		else $error("output stage overrun");

	// A valid box is well ordered
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_v_q && sum_q.box_valid) |->
		(sum_q.box_left <= sum_q.box_right) && (sum_q.box_top <= sum_q.box_bottom))
		else $error("bounding box inverted");

	// No box without a counted mismatch
	a_box_count: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_v_q && !sum_q.box_valid) |-> (sum_q.mismatch_count == '0))
		else $error("box valid disagrees with count");

endmodule
